// ----- rtl/crlf_bl_pkg.sv -----
// Shared types, constants and phase helpers for the CRLF blank-line remover.
`default_nettype none

package crlf_bl_pkg;

    localparam int SPACE_DEPTH_DEF = 32;
    localparam int QDEPTH          = 2;

    localparam logic [7:0] BYTE_CR  = 8'd13;
    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_SP  = 8'd32;
    localparam logic [7:0] BYTE_TAB = 8'd9;
    localparam logic [7:0] BYTE_VT  = 8'd11;
    localparam logic [7:0] BYTE_FF  = 8'd12;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_t;

    // Scan mode of the front end.
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_CR    = 2'd1,
        MODE_WS    = 2'd2,
        MODE_WS_CR = 2'd3
    } mode_t;

    // Emission command: items go out in the order flush, cr1, byte, cr_end.
    typedef struct packed {
        logic       flush;
        logic       cr1;
        logic       has_byte;
        logic [7:0] data;
        logic       cr_end;
    } cmd_t;

    // Back end phases, in emission order.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CR    = 3'd1,
        PH_LF    = 3'd2,
        PH_SPACE = 3'd3,
        PH_CR1   = 3'd4,
        PH_BYTE  = 3'd5,
        PH_CREND = 3'd6
    } phase_t;

    typedef struct packed {
        logic cmd_done;
        logic cmd_flush;
    } back_stat_t;

    function automatic logic is_hspace(input logic [7:0] b);
        return (b == BYTE_SP) || (b == BYTE_TAB) || (b == BYTE_VT) || (b == BYTE_FF);
    endfunction

    // First phase at or after 'from' that the command actually uses;
    // PH_IDLE as 'from' means the command is already past its end.
    function automatic phase_t next_phase(input cmd_t c, input logic has_sp,
                                          input phase_t from);
        phase_t p;
        p = PH_IDLE;
        priority if (from == PH_IDLE) begin
            p = PH_IDLE;
        end else if (from <= PH_CR && c.flush) begin
            p = PH_CR;
        end else if (from <= PH_LF && c.flush) begin
            p = PH_LF;
        end else if (from <= PH_SPACE && c.flush && has_sp) begin
            p = PH_SPACE;
        end else if (from <= PH_CR1 && c.cr1) begin
            p = PH_CR1;
        end else if (from <= PH_BYTE && c.has_byte) begin
            p = PH_BYTE;
        end else if (from <= PH_CREND && c.cr_end) begin
            p = PH_CREND;
        end else begin
            p = PH_IDLE;
        end
        return p;
    endfunction

    // Phase that follows in emission order; PH_IDLE past the end.
    function automatic phase_t succ_phase(input phase_t p);
        phase_t s;
        unique case (p)
            PH_CR:    s = PH_LF;
            PH_LF:    s = PH_SPACE;
            PH_SPACE: s = PH_CR1;
            PH_CR1:   s = PH_BYTE;
            PH_BYTE:  s = PH_CREND;
            default:  s = PH_IDLE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/crlf_bl_cmd_fifo.sv -----
// Short command queue between the classifier and the emitter.
`default_nettype none

module crlf_bl_cmd_fifo #(
    parameter int CW = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire crlf_bl_pkg::cmd_t    push_cmd,
    input  wire logic [CW-1:0]        push_count,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output crlf_bl_pkg::cmd_t         pop_cmd,
    output logic [CW-1:0]             pop_count
);

    localparam int QD = crlf_bl_pkg::QDEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int NW = $clog2(QD + 1);

    crlf_bl_pkg::cmd_t cmd_reg [QD];
    logic [CW-1:0]     count_reg [QD];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     fill_reg, fill_next;

    assign full      = (fill_reg == NW'(QD));
    assign not_empty = (fill_reg != '0);
    assign pop_cmd   = cmd_reg[rd_ptr_reg];
    assign pop_count = count_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + NW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_reg[wr_ptr_reg]   <= push_cmd;
            count_reg[wr_ptr_reg] <= push_count;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crlf_bl_front.sv -----
// Front end: accepts input bytes, tracks the scan mode and issues emission commands.
`default_nettype none

module crlf_bl_front #(
    parameter int SPACE_DEPTH = crlf_bl_pkg::SPACE_DEPTH_DEF,
    parameter int CW = $clog2(SPACE_DEPTH + 1),
    parameter int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire crlf_bl_pkg::in_t       s_data,
    input  wire logic                   q_full,
    output logic                        push,
    output crlf_bl_pkg::cmd_t           push_cmd,
    output logic [CW-1:0]               push_count,
    output logic                        st_we,
    output logic [AW-1:0]               st_addr,
    output logic [7:0]                  st_data,
    input  wire crlf_bl_pkg::back_stat_t back_stat
);

    localparam int FW = $clog2(crlf_bl_pkg::QDEPTH + 2);

    crlf_bl_pkg::mode_t mode_reg, mode_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [FW-1:0]      flush_cnt_reg, flush_cnt_next;

    crlf_bl_pkg::cmd_t  cmd;
    logic               wr_need;
    logic               accept;
    logic [7:0]         b;

    assign b = s_data.in_byte;

    // Classify the byte against the current mode.
    always_comb begin
        cmd        = '0;
        cmd.data   = b;
        mode_next  = mode_reg;
        count_next = count_reg;
        wr_need    = 1'b0;
        unique case (mode_reg)
            crlf_bl_pkg::MODE_PLAIN: begin
                if (b == crlf_bl_pkg::BYTE_CR) begin
                    mode_next = crlf_bl_pkg::MODE_CR;
                end else begin
                    cmd.has_byte = 1'b1;
                end
            end
            crlf_bl_pkg::MODE_CR: begin
                if (b == crlf_bl_pkg::BYTE_LF) begin
                    mode_next  = crlf_bl_pkg::MODE_WS;
                    count_next = '0;
                end else begin
                    cmd.cr1 = 1'b1;
                    if (b == crlf_bl_pkg::BYTE_CR) begin
                        mode_next = crlf_bl_pkg::MODE_CR;
                    end else begin
                        cmd.has_byte = 1'b1;
                        mode_next    = crlf_bl_pkg::MODE_PLAIN;
                    end
                end
            end
            crlf_bl_pkg::MODE_WS: begin
                if (b == crlf_bl_pkg::BYTE_CR) begin
                    mode_next = crlf_bl_pkg::MODE_WS_CR;
                end else if (crlf_bl_pkg::is_hspace(b) && (count_reg < CW'(SPACE_DEPTH))) begin
                    wr_need    = 1'b1;
                    count_next = count_reg + CW'(1);
                end else begin
                    // not blank, or whitespace overflow
                    cmd.flush    = 1'b1;
                    cmd.has_byte = 1'b1;
                    mode_next    = crlf_bl_pkg::MODE_PLAIN;
                    count_next   = '0;
                end
            end
            crlf_bl_pkg::MODE_WS_CR: begin
                if (b == crlf_bl_pkg::BYTE_LF) begin
                    // blank line dropped, new CR LF held
                    mode_next  = crlf_bl_pkg::MODE_WS;
                    count_next = '0;
                end else begin
                    cmd.flush  = 1'b1;
                    cmd.cr1    = 1'b1;
                    count_next = '0;
                    if (b == crlf_bl_pkg::BYTE_CR) begin
                        mode_next = crlf_bl_pkg::MODE_CR;
                    end else begin
                        cmd.has_byte = 1'b1;
                        mode_next    = crlf_bl_pkg::MODE_PLAIN;
                    end
                end
            end
            default: begin
                mode_next = crlf_bl_pkg::MODE_PLAIN;
            end
        endcase

        // end of stream: release what is held, drop a pending blank line
        if (s_data.in_last) begin
            if (mode_next == crlf_bl_pkg::MODE_CR) begin
                cmd.cr_end = 1'b1;
            end else if (mode_next == crlf_bl_pkg::MODE_WS_CR) begin
                cmd.flush  = 1'b1;
                cmd.cr_end = 1'b1;
            end
            mode_next  = crlf_bl_pkg::MODE_PLAIN;
            count_next = '0;
        end
    end

    // Whitespace store may not be rewritten while a flush still reads it.
    assign s_ready    = !q_full && !(wr_need && (flush_cnt_reg != '0));
    assign accept     = s_valid && s_ready;
    assign push       = accept && (cmd.flush || cmd.cr1 || cmd.has_byte || cmd.cr_end);
    assign push_cmd   = cmd;
    assign push_count = count_reg;
    assign st_we      = accept && wr_need;
    assign st_addr    = AW'(count_reg);
    assign st_data    = b;

    always_comb begin
        flush_cnt_next = flush_cnt_reg;
        if ((push && cmd.flush) && !(back_stat.cmd_done && back_stat.cmd_flush)) begin
            flush_cnt_next = flush_cnt_reg + FW'(1);
        end else if (!(push && cmd.flush) && (back_stat.cmd_done && back_stat.cmd_flush)) begin
            flush_cnt_next = flush_cnt_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= crlf_bl_pkg::MODE_PLAIN;
            count_reg     <= '0;
            flush_cnt_reg <= '0;
        end else begin
            flush_cnt_reg <= flush_cnt_next;
            if (accept) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crlf_bl_back.sv -----
// Back end: whitespace store and emitter, playing commands out one byte a cycle unless stalled.
`default_nettype none

module crlf_bl_back #(
    parameter int SPACE_DEPTH = crlf_bl_pkg::SPACE_DEPTH_DEF,
    parameter int CW = $clog2(SPACE_DEPTH + 1),
    parameter int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire crlf_bl_pkg::cmd_t    q_cmd,
    input  wire logic [CW-1:0]        q_count,
    output logic                      q_pop,
    input  wire logic                 st_we,
    input  wire logic [AW-1:0]        st_addr,
    input  wire logic [7:0]           st_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output crlf_bl_pkg::out_t         m_data,
    output crlf_bl_pkg::back_stat_t   back_stat
);

    logic [7:0] space_mem [SPACE_DEPTH];
    logic [7:0] rd_data_reg;

    crlf_bl_pkg::phase_t phase_reg, phase_next, after;
    crlf_bl_pkg::cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    crlf_bl_pkg::out_t   m_data_reg, m_data_next;

    logic slot_free;
    logic emit;
    logic more_space;

    assign slot_free  = !m_valid_reg || m_ready;
    assign emit       = (phase_reg != crlf_bl_pkg::PH_IDLE) && slot_free;
    assign more_space = (CW'(idx_reg) + CW'(1)) < cnt_reg;

    // Phase sequencing and command load.
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        after      = crlf_bl_pkg::PH_IDLE;
        if (phase_reg == crlf_bl_pkg::PH_SPACE && more_space) begin
            after = crlf_bl_pkg::PH_SPACE;
        end else begin
            after = crlf_bl_pkg::next_phase(cmd_reg, cnt_reg != '0,
                                            crlf_bl_pkg::succ_phase(phase_reg));
        end

        if (phase_reg == crlf_bl_pkg::PH_IDLE || (emit && after == crlf_bl_pkg::PH_IDLE)) begin
            if (q_valid) begin
                q_pop      = 1'b1;
                cmd_next   = q_cmd;
                cnt_next   = q_count;
                idx_next   = '0;
                phase_next = crlf_bl_pkg::next_phase(q_cmd, q_count != '0,
                                                     crlf_bl_pkg::PH_CR);
            end else begin
                phase_next = crlf_bl_pkg::PH_IDLE;
            end
        end else if (emit) begin
            phase_next = after;
            if (phase_reg == crlf_bl_pkg::PH_SPACE && more_space) begin
                idx_next = idx_reg + AW'(1);
            end
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next         = 1'b1;
            m_data_next.run_last = (after == crlf_bl_pkg::PH_IDLE);
            unique case (phase_reg)
                crlf_bl_pkg::PH_LF:    m_data_next.out_byte = crlf_bl_pkg::BYTE_LF;
                crlf_bl_pkg::PH_SPACE: m_data_next.out_byte = rd_data_reg;
                crlf_bl_pkg::PH_BYTE:  m_data_next.out_byte = cmd_reg.data;
                default:               m_data_next.out_byte = crlf_bl_pkg::BYTE_CR;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign back_stat = '{cmd_done:  emit && (after == crlf_bl_pkg::PH_IDLE),
                         cmd_flush: cmd_reg.flush};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= crlf_bl_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    // Store: one write port, registered read that tracks the next index.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            space_mem[st_addr] <= st_data;
        end
        rd_data_reg <= space_mem[idx_next];
    end

endmodule

`default_nettype wire

// ----- rtl/crlf_blank_line_remover.sv -----
// Top level of the CRLF blank-line remover byte filter.
`default_nettype none

// Byte-stream filter that drops blank CRLF lines: a CR LF followed by spaces,
// tabs, VT or FF and then another CR LF (or the end of the stream) is removed
// along with its whitespace; anything else is passed through unchanged. Each
// request on s_ carries one byte and a last flag; each request on m_ carries
// one kept byte, with run_last set on the final byte that a given input caused.
// A front end classifies bytes and writes whitespace into a SPACE_DEPTH-entry
// store in the back end; it hands emission commands through a two-entry queue
// to the back end, which plays them out one byte per cycle into the output
// register while the output is not stalled. Plain text runs at one byte per
// cycle under the same condition. The rate is set by the single output port:
// an input whose line is flushed puts out CR, LF, the N held whitespace bytes
// and the byte itself, plus one or two CRs when a held CR is released with it,
// and the front end holds off new whitespace while a flush is still reading
// the store. The store needs no clearing after reset.
module crlf_blank_line_remover #(
    parameter int SPACE_DEPTH = crlf_bl_pkg::SPACE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire crlf_bl_pkg::in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output crlf_bl_pkg::out_t      m_data
);

    localparam int CW = $clog2(SPACE_DEPTH + 1);
    localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    // front -> queue
    logic                    push;
    crlf_bl_pkg::cmd_t       push_cmd;
    logic [CW-1:0]           push_count;
    logic                    q_full;

    // queue -> back
    logic                    q_pop;
    logic                    q_valid;
    crlf_bl_pkg::cmd_t       q_cmd;
    logic [CW-1:0]           q_count;

    // whitespace store write port, owned by the front
    logic                    st_we;
    logic [AW-1:0]           st_addr;
    logic [7:0]              st_data;

    // back -> front: tells when a flush has finished reading the store
    crlf_bl_pkg::back_stat_t back_stat;

    crlf_bl_front #(
        .SPACE_DEPTH (SPACE_DEPTH),
        .CW          (CW),
        .AW          (AW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_count (push_count),
        .st_we      (st_we),
        .st_addr    (st_addr),
        .st_data    (st_data),
        .back_stat  (back_stat)
    );

    crlf_bl_cmd_fifo #(
        .CW (CW)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_count (push_count),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .pop_cmd    (q_cmd),
        .pop_count  (q_count)
    );

    crlf_bl_back #(
        .SPACE_DEPTH (SPACE_DEPTH),
        .CW          (CW),
        .AW          (AW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_count   (q_count),
        .q_pop     (q_pop),
        .st_we     (st_we),
        .st_addr   (st_addr),
        .st_data   (st_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .back_stat (back_stat)
    );

endmodule

`default_nettype wire
